// ----- src/rbsub_pkg.sv -----
// Shared constants and types for the radix-10000 bignum subtractor.
package rbsub_pkg;

  localparam int LIMB_W        = 14;     // width of one limb on the ports
  localparam int MAX_LIMBS_DEF = 16;     // default operand capacity in limbs
  localparam int RADIX_DEF     = 10000;  // default limb radix

  typedef logic [LIMB_W-1:0] limb_t;

  typedef enum logic [1:0] {
    S_LOAD,  // taking limb pairs
    S_CMP,   // magnitude compare, top limb down
    S_SUB,   // borrow subtract, bottom limb up
    S_EMIT   // stream difference limbs, top first
  } state_e;

endpackage

// ----- src/rbsub_if.sv -----
// Request and result channel interfaces of the bignum subtractor.
interface rbsub_in_if import rbsub_pkg::*; ();
  logic  valid;
  logic  ready;
  limb_t limb_a;
  limb_t limb_b;
  logic  last_in;

  modport source (output valid, limb_a, limb_b, last_in, input ready);
  modport sink   (input valid, limb_a, limb_b, last_in, output ready);
endinterface

interface rbsub_out_if import rbsub_pkg::*; ();
  logic  valid;
  logic  ready;
  limb_t diff_limb;
  logic  negative;
  logic  last_out;
  logic  too_long;

  modport source (output valid, diff_limb, negative, last_out, too_long, input ready);
  modport sink   (input valid, diff_limb, negative, last_out, too_long, output ready);
endinterface

// ----- src/rbsub_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rbsub_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/radix10000_bignum_subtractor_core.sv -----
// Sign-magnitude subtractor for unsigned numbers held as base-RADIX limbs. Requests carry one
// limb pair (minuend limb_a, subtrahend limb_b), most significant first, and last_in marks the
// least significant pair. A limb above RADIX-1 is clamped to RADIX-1. Up to MAX_LIMBS pairs are
// stored; later pairs of the same operands are dropped and too_long is raised on every limb of
// that result. Once the last pair is in, the block compares the stored magnitudes from the top
// limb, swaps the operands if the minuend is the smaller, subtracts with a borrow rippling from
// the bottom limb up, and returns |a - b| one limb per result, most significant first, with
// negative set when the operands were swapped and last_out on the bottom limb. Requests are taken
// one pair per cycle while loading. After the last pair come a compare walk that stops at the
// first unequal limb pair, a subtract walk over all stored limbs and an emission walk, each paced by
// the registered read of the limb and difference stores; the emission issues a read only when no
// read is in flight and the output register is free or being taken, so it stalls with the output.
// New requests are taken again as soon as the bottom result limb sits in the output register,
// while it still waits to be taken.
module radix10000_bignum_subtractor_core import rbsub_pkg::*; #(
  parameter int MAX_LIMBS = MAX_LIMBS_DEF,
  parameter int RADIX     = RADIX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rbsub_in_if.sink    req_i,
  rbsub_out_if.source res_o
);

  localparam int IW = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;  // store index
  localparam int CW = $clog2(MAX_LIMBS + 1);                    // limb count
  localparam int XW = LIMB_W + 3;                               // clamp compare
  localparam int SW = LIMB_W + 4;                               // signed limb difference
  localparam int RMAX = RADIX - 1;

  state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;        // stored limb pairs
  logic          ovf_q, ovf_d;        // pairs dropped for capacity
  logic          swap_q;
  logic          borrow_q;
  logic [IW-1:0] addr_q;              // walk read address
  logic [IW-1:0] raddr_q;             // address of data now on the read port
  logic [CW-1:0] walk_q;              // reads still to issue
  logic          rv_q;                // read data valid this cycle
  logic          rlast_q;             // it is the last of the walk

  logic          out_valid_q;
  limb_t         out_limb_q;
  logic          out_neg_q;
  logic          out_last_q;
  logic          out_long_q;

  // control
  logic in_acc, store_we, issue, cmp_done, out_load, out_pop;

  // store datapath
  limb_t             a_cl, b_cl;
  logic [2*LIMB_W-1:0] st_rdata;
  limb_t             a_rd, b_rd, top, bot, diff, dif_rdata;
  logic [SW-1:0]     sub_t, sub_adj;
  logic              sub_neg, a_lt, a_gt;

  // ---------------------------------------------------------------------------
  // Input clamp: values past RADIX-1 saturate
  // ---------------------------------------------------------------------------
  always_comb begin
    a_cl = (XW'(req_i.limb_a) > XW'(RMAX)) ? LIMB_W'(RMAX) : req_i.limb_a;
    b_cl = (XW'(req_i.limb_b) > XW'(RMAX)) ? LIMB_W'(RMAX) : req_i.limb_b;
  end

  assign in_acc   = req_i.valid && req_i.ready;
  assign store_we = in_acc && (cnt_q < CW'(MAX_LIMBS));

  // count and drop flag clear once the bottom limb has gone to the output register
  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (in_acc) begin
      if (store_we) cnt_d = cnt_q + CW'(1);
      else          ovf_d = 1'b1;
    end
    if (state_q == S_EMIT && state_d == S_LOAD) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end
  end

  // Operand store: {minuend, subtrahend} per limb position
  rbsub_ram #(.WIDTH(2 * LIMB_W), .DEPTH(MAX_LIMBS)) u_opnd_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i ({a_cl, b_cl}),
    .raddr_i (addr_q),
    .rdata_o (st_rdata)
  );

  assign a_rd = st_rdata[2*LIMB_W-1:LIMB_W];
  assign b_rd = st_rdata[LIMB_W-1:0];
  assign a_lt = a_rd < b_rd;
  assign a_gt = a_rd > b_rd;
  assign cmp_done = a_lt || a_gt || rlast_q;

  // Borrow subtract of the larger minus the smaller
  always_comb begin
    top     = swap_q ? b_rd : a_rd;
    bot     = swap_q ? a_rd : b_rd;
    sub_t   = SW'(top) - SW'(bot) - SW'(borrow_q);
    sub_neg = sub_t[SW-1];
    sub_adj = sub_neg ? (sub_t + SW'(RADIX)) : sub_t;
    diff    = sub_adj[LIMB_W-1:0];
  end

  // Difference store, written bottom up and read top down
  rbsub_ram #(.WIDTH(LIMB_W), .DEPTH(MAX_LIMBS)) u_diff_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == S_SUB) && rv_q),
    .waddr_i (raddr_q),
    .wdata_i (diff),
    .raddr_i (addr_q),
    .rdata_o (dif_rdata)
  );

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:  if (in_acc && req_i.last_in) state_d = S_CMP;
      S_CMP:   if (rv_q && cmp_done)        state_d = S_SUB;
      S_SUB:   if (rv_q && rlast_q)         state_d = S_EMIT;
      S_EMIT:  if (rv_q && rlast_q)         state_d = S_LOAD;
      default: state_d = S_LOAD;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    issue    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      S_LOAD:  issue = 1'b0;
      S_CMP:   issue = (walk_q != '0) && !(rv_q && cmp_done);
      S_SUB:   issue = (walk_q != '0);
      S_EMIT: begin
        // one read in flight; slot is free when the data lands
        issue    = (walk_q != '0) && !rv_q && (!out_valid_q || res_o.ready);
        out_load = rv_q;
      end
      default: issue = 1'b0;
    endcase
  end

  assign req_i.ready = (state_q == S_LOAD);
  assign out_pop     = out_valid_q && res_o.ready;

  // ---------------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------------
  // No read is issued on a walk's final cycle, so rv_q drops by itself there.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      swap_q   <= 1'b0;
      borrow_q <= 1'b0;
      addr_q   <= '0;
      raddr_q  <= '0;
      walk_q   <= '0;
      rv_q     <= 1'b0;
      rlast_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      rv_q    <= issue;
      if (issue) begin
        rlast_q <= (walk_q == CW'(1));
        raddr_q <= addr_q;
        walk_q  <= walk_q - CW'(1);
        addr_q  <= (state_q == S_SUB) ? (addr_q - IW'(1)) : (addr_q + IW'(1));
      end
      if (state_q == S_SUB && rv_q) begin
        borrow_q <= sub_neg;
      end
      case (state_q)
        S_LOAD: begin
          if (state_d == S_CMP) begin
            addr_q <= '0;
            walk_q <= cnt_d;
          end
        end
        S_CMP: begin
          if (state_d == S_SUB) begin
            swap_q   <= a_lt;
            borrow_q <= 1'b0;
            addr_q   <= IW'(cnt_q - CW'(1));
            walk_q   <= cnt_q;
          end
        end
        S_SUB: begin
          if (state_d == S_EMIT) begin
            addr_q <= '0;
            walk_q <= cnt_q;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_limb_q <= dif_rdata;
      out_neg_q  <= swap_q;
      out_last_q <= rlast_q;
      out_long_q <= ovf_q;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.diff_limb = out_limb_q;
  assign res_o.negative  = out_neg_q;
  assign res_o.last_out  = out_last_q;
  assign res_o.too_long  = out_long_q;

endmodule
